>>> hw/rtl/hwt_pkg.sv
// Shared command types for the hashed timing wheel.
package hwt_pkg;

   localparam int unsigned ID_W     = 4;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned SLOT_O_W = 2;

   typedef enum logic [1:0] {
      REQ_ARM    = 2'd0,
      REQ_DISARM = 2'd1,
      REQ_TICK   = 2'd2
   } req_code_type;

   typedef struct packed {
      req_code_type          kind;
      logic [ID_W-1:0]       id;
      logic [PERIOD_W-1:0]   period;
      logic                  one_shot;
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [PERIOD_W-1:0]   dividend;
   } div_req_type;

endpackage

>>> hw/rtl/hwt_if.sv
// Valid/ready channel interfaces for requests and firings.
interface hwt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  timer_id;
   logic [15:0] period_sec;
   logic        one_time;
   modport source(output valid, req_type, timer_id, period_sec, one_time, input ready);
   modport sink(input valid, req_type, timer_id, period_sec, one_time, output ready);
endinterface

interface hwt_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] fired_timer_id;
   logic [1:0] wheel_slot;
   logic       last;
   modport source(output valid, fired_timer_id, wheel_slot, last, input ready);
   modport sink(input valid, fired_timer_id, wheel_slot, last, output ready);
endinterface

>>> hw/rtl/hwt_front.sv
// Request classifier and two-entry command queue.
module hwt_front
   import hwt_pkg::*;
#(
   parameter int unsigned TIMER_ENTRIES = 16
) (
   input  logic      clock,
   input  logic      reset,
   hwt_req_if.sink   req_chan,
   output logic      cmd_valid,
   output cmd_type   cmd,
   input  logic      cmd_pop
);

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        take;
   logic        keep;
   cmd_type     new_cmd;

   assign req_chan.ready = (count_ff != 2'd2);
   assign take = req_chan.valid && req_chan.ready;

   // drop unknown codes and ids beyond the table
   always_comb begin
      new_cmd.kind     = req_code_type'(req_chan.req_type);
      new_cmd.id       = req_chan.timer_id;
      new_cmd.period   = req_chan.period_sec;
      new_cmd.one_shot = req_chan.one_time;
      case (req_chan.req_type)
         REQ_ARM, REQ_DISARM: keep = (32'(req_chan.timer_id) < TIMER_ENTRIES);
         REQ_TICK:            keep = 1'b1;
         default:             keep = 1'b0;
      endcase
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (take && keep) begin
         wr_ptr_in = ~wr_ptr_ff;
         count_in  = count_in + 2'd1;
      end
      if (cmd_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
         count_in  = count_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && keep) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> hw/rtl/hwt_div.sv
// Divider by the slot count: reciprocal multiply, then remainder, in registered steps.
module hwt_div
   import hwt_pkg::*;
#(
   parameter int unsigned WHEEL_SLOTS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  div_req_type                          div_req,
   output logic                                 done,
   output logic [PERIOD_W-1:0]                  quotient,
   output logic [$clog2(WHEEL_SLOTS+1)-1:0]     remainder
);

   localparam int unsigned DW = $clog2(WHEEL_SLOTS + 1);
   localparam int unsigned SH = PERIOD_W + $clog2(WHEEL_SLOTS);
   localparam int unsigned MW = PERIOD_W + 2;
   localparam int unsigned PW = PERIOD_W + MW;
   // ceil(2^SH / W) is exact for every dividend below 2^PERIOD_W
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);
   localparam logic [MW-1:0]       RECIP_V = MW'(RECIP);
   localparam logic [PERIOD_W-1:0] DIV_V   = PERIOD_W'(WHEEL_SLOTS);

   logic                mul_ff;
   logic                sub_ff;
   logic                done_ff;
   logic [PERIOD_W-1:0] dvd_ff;
   logic [PERIOD_W-1:0] quo_ff, quo_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [PW-1:0]       prod;
   logic [PERIOD_W-1:0] quo_x_div;

   always_comb begin
      prod      = {{MW{1'b0}}, dvd_ff} * {{PERIOD_W{1'b0}}, RECIP_V};
      quo_in    = PERIOD_W'(prod >> SH);
      quo_x_div = quo_ff * DIV_V;
      rem_in    = DW'(dvd_ff - quo_x_div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= div_req.start;
         sub_ff  <= mul_ff;
         done_ff <= sub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
      end
      if (mul_ff) begin
         quo_ff <= quo_in;
      end
      if (sub_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/hwt_back.sv
// Timer table, arm/disarm sequencer and tick scan with output register.
module hwt_back
   import hwt_pkg::*;
#(
   parameter int unsigned WHEEL_SLOTS   = 4,
   parameter int unsigned TIMER_ENTRIES = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   hwt_rsp_if.source rsp_chan
);

   localparam int unsigned SLOT_W = $clog2(WHEEL_SLOTS);
   localparam int unsigned IDX_W  = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
   localparam int unsigned DW     = $clog2(WHEEL_SLOTS + 1);
   localparam logic [SLOT_W:0] W_L = (SLOT_W + 1)'(WHEEL_SLOTS);
   localparam logic [IDX_W:0]  LAST_IDX = (IDX_W + 1)'(TIMER_ENTRIES - 1);

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [SLOT_W-1:0]   offset;
      logic [PERIOD_W-1:0] rounds;
      logic [PERIOD_W-1:0] rounds_init;
      logic                one_shot;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_ARM_WR, S_SCAN_RD, S_SCAN_EV, S_FLUSH
   } state_type;

   state_type            state_ff;
   logic [SLOT_W-1:0]    cur_ff;
   logic [TIMER_ENTRIES-1:0] active_ff;
   logic [IDX_W:0]       idx_ff;
   logic [IDX_W-1:0]     idx;
   cmd_type              arm_ff;
   logic [IDX_W-1:0]     arm_idx;
   logic                 pend_valid_ff;
   logic [IDX_W-1:0]     pend_idx_ff;
   logic                 out_valid_ff;
   logic [ID_W-1:0]      out_id_ff;
   logic [SLOT_O_W-1:0]  out_slot_ff;
   logic                 out_last_ff;
   logic                 can_push;
   logic                 out_load;

   entry_type            mem [TIMER_ENTRIES];
   entry_type            rd_data_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;

   div_req_type          div_req;
   logic                 div_done;
   logic [PERIOD_W-1:0]  div_q;
   logic [DW-1:0]        div_r;

   logic [SLOT_W:0]      rem_inc;
   logic [SLOT_W-1:0]    arm_offset;
   logic [SLOT_W-1:0]    arm_slot;
   logic [SLOT_W-1:0]    rearm_slot;
   logic [SLOT_W-1:0]    cur_next;
   logic                 hit;
   logic                 fire;

   function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a,
                                                  logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= W_L) begin
         s = s - W_L;
      end
      return s[SLOT_W-1:0];
   endfunction

   hwt_div #(.WHEEL_SLOTS(WHEEL_SLOTS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign idx     = idx_ff[IDX_W-1:0];
   assign arm_idx = IDX_W'(arm_ff.id);
   assign can_push = !out_valid_ff || rsp_chan.ready;
   assign cur_next = ({1'b0, cur_ff} == W_L - 1'b1) ? '0 : cur_ff + 1'b1;

   // load the output register with a held firing
   assign out_load = ((state_ff == S_SCAN_EV) && fire && pend_valid_ff && can_push) ||
                     ((state_ff == S_FLUSH) && pend_valid_ff && can_push);

   // (period-1) mod W plus one, folded back into the wheel
   always_comb begin
      rem_inc    = (SLOT_W + 1)'(div_r) + 1'b1;
      arm_offset = (rem_inc == W_L) ? '0 : rem_inc[SLOT_W-1:0];
      if (arm_ff.period == '0) begin
         arm_offset = '0;
      end
      arm_slot   = slot_add(cur_ff, arm_offset);
      rearm_slot = slot_add(cur_ff, rd_data_ff.offset);
      hit  = active_ff[idx] && (rd_data_ff.slot == cur_ff);
      fire = hit && (rd_data_ff.rounds == '0);
   end

   always_comb begin
      cmd_pop = (state_ff == S_IDLE) && cmd_valid;
      div_req.start    = cmd_pop && (cmd.kind == REQ_ARM) && (cmd.period != '0);
      div_req.dividend = cmd.period - 1'b1;
      wr_en   = 1'b0;
      wr_addr = idx;
      wr_data = rd_data_ff;
      case (state_ff)
         S_ARM_WR: begin
            wr_en               = 1'b1;
            wr_addr             = arm_idx;
            wr_data.slot        = arm_slot;
            wr_data.offset      = arm_offset;
            wr_data.rounds      = (arm_ff.period == '0) ? '0 : div_q;
            wr_data.rounds_init = (arm_ff.period == '0) ? '0 : div_q;
            wr_data.one_shot    = arm_ff.one_shot;
         end
         S_SCAN_EV: begin
            if (fire && !(pend_valid_ff && !can_push)) begin
               wr_en          = !rd_data_ff.one_shot;
               wr_data.slot   = rearm_slot;
               wr_data.rounds = rd_data_ff.rounds_init;
            end else if (hit && !fire) begin
               wr_en          = 1'b1;
               wr_data.rounds = rd_data_ff.rounds - 1'b1;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         active_ff     <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  arm_ff <= cmd;
                  case (cmd.kind)
                     REQ_ARM: begin
                        state_ff <= (cmd.period == '0) ? S_ARM_WR : S_DIV;
                     end
                     REQ_DISARM: begin
                        active_ff[IDX_W'(cmd.id)] <= 1'b0;
                     end
                     REQ_TICK: begin
                        cur_ff   <= cur_next;
                        idx_ff   <= '0;
                        state_ff <= S_SCAN_RD;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_ARM_WR;
               end
            end
            S_ARM_WR: begin
               active_ff[arm_idx] <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_EV;
            end
            S_SCAN_EV: begin
               if (!(fire && pend_valid_ff && !can_push)) begin
                  if (fire) begin
                     // release the held firing: a later one exists
                     if (pend_valid_ff) begin
                        out_id_ff    <= ID_W'(pend_idx_ff);
                        out_slot_ff  <= SLOT_O_W'(cur_ff);
                        out_last_ff  <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_idx_ff   <= idx;
                     if (rd_data_ff.one_shot) begin
                        active_ff[idx] <= 1'b0;
                     end
                  end
                  if (idx_ff == LAST_IDX) begin
                     state_ff <= S_FLUSH;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            S_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (can_push) begin
                  out_id_ff     <= ID_W'(pend_idx_ff);
                  out_slot_ff   <= SLOT_O_W'(cur_ff);
                  out_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.fired_timer_id = out_id_ff;
   assign rsp_chan.wheel_slot     = out_slot_ff;
   assign rsp_chan.last           = out_last_ff;

endmodule

>>> hw/rtl/hashed_timing_wheel_core.sv
// Top level of the hashed timing wheel: request queue feeding the wheel engine.
//
// Usage: requests enter on req_chan (valid/ready), one transfer per request:
// arm (0) places timer_id on the wheel period_sec ticks ahead, disarm (1)
// clears it, tick (2) advances the wheel. Ids beyond the table and code 3
// are dropped at the front. Firings leave on rsp_chan, one transfer each, in
// ascending id order; last marks the final firing of a tick, and a tick
// with nothing due produces no transfer.
// Timing: a request reaches the engine the cycle after its transfer, or
// later while the engine still works on earlier requests (two-entry queue).
// A disarm is done in the engine's idle state. An arm with nonzero period
// goes from idle through the wait on the reciprocal-multiply divider to the
// table write; a period of zero skips the divider. A tick scans the whole
// table, one memory read and one evaluate/write per entry, then a flush.
// Firings trail the scan by one firing, since the last flag is known only when
// the next firing or the end of the scan is seen.
// Reset clears the wheel position, all armed flags and both queues at once;
// the entry table needs no clearing. When the receiver stalls, the scan
// holds on the next firing until the output register frees up, and the front
// queue then fills and drops req_chan.ready.
module hashed_timing_wheel_core
   import hwt_pkg::*;
#(
   parameter int unsigned WHEEL_SLOTS   = 4,
   parameter int unsigned TIMER_ENTRIES = 16
) (
   input  logic      clock,
   input  logic      reset,
   hwt_req_if.sink   req_chan,
   hwt_rsp_if.source rsp_chan
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // front: classify and queue requests
   hwt_front #(.TIMER_ENTRIES(TIMER_ENTRIES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // back: table updates, tick scan and the firing output register
   hwt_back #(
      .WHEEL_SLOTS   (WHEEL_SLOTS),
      .TIMER_ENTRIES (TIMER_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
